// ----- sv/sbus_frame_receiver_decoder_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the serial RC frame decoder
// Concurrent assertion wrappers clocked on aclk, empty outside simulation.
// ---------------------------------------------------------------------------
`ifndef SBUS_FRAME_RECEIVER_DECODER_TOP_MACROS_SVH
`define SBUS_FRAME_RECEIVER_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define SFRD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked at every edge, reset included.
`define SFRD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define SFRD_ASSERT(label, prop, msg)
`define SFRD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- sv/sfrd_pkg.sv -----
// ---------------------------------------------------------------------------
// Serial RC frame decoder package
// Shared constants for the frame byte chain and the decoder top level.
// ---------------------------------------------------------------------------
package sfrd_pkg;

    localparam int FRAME_BYTES_DEFAULT = 24;
    localparam int BYTE_W = 8;
    localparam int CHAN_W = 12;
    localparam int RAW_W = 11;
    localparam int COUNT_W = 16;
    localparam int TICK_W = 16;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h0F;
    localparam logic [CHAN_W-1:0] CHAN_OFFSET = 12'd1980;
    localparam int LOST_BIT = 2;
    localparam int FAILSAFE_BIT = 3;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

endpackage

// ----- sv/sfrd_byte_cell.sv -----
// ---------------------------------------------------------------------------
// Frame byte cell
// One byte of the frame chain; loads its neighbor's byte on each shift.
// ---------------------------------------------------------------------------
module sfrd_byte_cell (
    input  logic                       aclk,
    input  logic                       shift_en,
    input  logic [sfrd_pkg::BYTE_W-1:0] byte_in,
    output logic [sfrd_pkg::BYTE_W-1:0] byte_out
);
    import sfrd_pkg::*;

    logic [BYTE_W-1:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

endmodule

// ----- sv/sbus_frame_receiver_decoder_top.sv -----
// ---------------------------------------------------------------------------
// Serial RC frame receiver and decoder
// Frames received bytes on sync and gap timing and unpacks seven channels.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_opcode, s_rx_byte
//  m_        out        m_valid/m_ready    m_chan_one..m_chan_seven, counts, link_up
//  cfg_      in         cfg_wr_en          cfg_wr_data (gap_ticks)
//
//  The block takes one transaction per clock cycle unless stalled. A byte
//  or tick is absorbed in the cycle it is accepted; the first byte after a
//  full frame triggers the decode and loads the output register at that
//  edge, so its result is visible on the next cycle. The only stall is the
//  output register: s_ready drops only while a result is held and m_ready
//  is low. Reset clears the tick timer, the byte position and the flag
//  counters. The byte chain needs no reset, since a frame is decoded only
//  after all of its bytes have been shifted in.
//
module sbus_frame_receiver_decoder_top #(
    parameter int FRAME_BYTES = sfrd_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration
    input  logic                         cfg_wr_en,
    input  logic [sfrd_pkg::BYTE_W-1:0]  cfg_wr_data,
    // Input transactions
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_opcode,
    input  logic [sfrd_pkg::BYTE_W-1:0]  s_rx_byte,
    // Result transactions
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sfrd_pkg::CHAN_W-1:0]  m_chan_one,
    output logic [sfrd_pkg::CHAN_W-1:0]  m_chan_two,
    output logic [sfrd_pkg::CHAN_W-1:0]  m_chan_three,
    output logic [sfrd_pkg::CHAN_W-1:0]  m_chan_four,
    output logic [sfrd_pkg::CHAN_W-1:0]  m_chan_five,
    output logic [sfrd_pkg::CHAN_W-1:0]  m_chan_six,
    output logic [sfrd_pkg::CHAN_W-1:0]  m_chan_seven,
    output logic [sfrd_pkg::COUNT_W-1:0] m_lost_frames,
    output logic [sfrd_pkg::COUNT_W-1:0] m_failsafe_frames,
    output logic                         m_link_up
);
    import sfrd_pkg::*;
    `include "sbus_frame_receiver_decoder_top_macros.svh"

    // The position runs from zero to one past the frame length, which marks
    // a frame that has already been decoded.
    localparam int POS_W = $clog2(FRAME_BYTES + 2);
    localparam logic [POS_W-1:0] POS_FULL = POS_W'(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_DONE = POS_W'(FRAME_BYTES + 1);

    logic [BYTE_W-1:0]  gap_ticks_reg;
    logic [TICK_W-1:0]  tick_count_reg;
    logic [TICK_W-1:0]  frame_start_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [COUNT_W-1:0] lost_reg;
    logic [COUNT_W-1:0] lost_next;
    logic [COUNT_W-1:0] failsafe_reg;
    logic [COUNT_W-1:0] failsafe_next;
    logic               out_valid_reg;

    logic [CHAN_W-1:0]  chan_reg [7];
    logic [CHAN_W-1:0]  chan_next [7];
    logic               link_up_reg;

    logic               accept;
    logic               byte_acc;
    logic               tick_acc;
    logic               restart;
    logic               shift_en;
    logic               decode;
    logic [TICK_W-1:0]  elapsed;

    // Byte chain: cell 0 takes the incoming byte, the oldest byte sits at
    // the far end. Once a frame is full, frame byte j lives in cell N-1-j.
    logic [BYTE_W-1:0]  chain [FRAME_BYTES];

    assign s_ready  = !out_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign byte_acc = accept && (s_opcode == OP_BYTE);
    assign tick_acc = accept && (s_opcode == OP_TICK);

    // Elapsed ticks wrap with the timer, so a plain 16-bit difference works.
    assign elapsed  = tick_count_reg - frame_start_reg;
    assign restart  = byte_acc && (s_rx_byte == SYNC_BYTE)
                      && (elapsed >= {{(TICK_W-BYTE_W){1'b0}}, gap_ticks_reg});

    // A restarting sync byte is stored as byte zero; bytes past a full
    // frame leave the chain alone.
    assign shift_en = restart || (byte_acc && (pos_reg < POS_FULL));
    assign decode   = byte_acc && !restart && (pos_reg == POS_FULL);

    for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_cell
        if (k == 0) begin : g_head
            sfrd_byte_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .byte_in  (s_rx_byte),
                .byte_out (chain[k])
            );
        end else begin : g_body
            sfrd_byte_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .byte_in  (chain[k-1]),
                .byte_out (chain[k])
            );
        end
    end

    // Frame bytes used by the decoder, named by their place in the frame.
    logic [BYTE_W-1:0] fb [11];
    logic [BYTE_W-1:0] flags;
    logic [RAW_W-1:0]  raw [7];

    always_comb begin
        for (int j = 0; j < 11; j++) begin
            fb[j] = chain[FRAME_BYTES-1-j];
        end
        flags = chain[0];

        raw[0] = {fb[2][2:0], fb[1]};
        raw[1] = {fb[3][5:0], fb[2][7:3]};
        raw[2] = {fb[5][0],   fb[4],      fb[3][7:6]};
        raw[3] = {fb[6][3:0], fb[5][7:1]};
        raw[4] = {fb[7][6:0], fb[6][7:4]};
        raw[5] = {fb[9][1:0], fb[8],      fb[7][7]};
        raw[6] = {fb[10][4:0], fb[9][7:2]};

        for (int c = 0; c < 7; c++) begin
            chan_next[c] = {1'b0, raw[c]} + CHAN_OFFSET;
        end
    end

    always_comb begin
        pos_next      = pos_reg;
        lost_next     = lost_reg;
        failsafe_next = failsafe_reg;
        if (restart) begin
            pos_next = POS_W'(1);
        end else if (shift_en) begin
            pos_next = pos_reg + POS_W'(1);
        end else if (decode) begin
            pos_next = POS_DONE;
            lost_next     = lost_reg + COUNT_W'(flags[LOST_BIT]);
            failsafe_next = failsafe_reg + COUNT_W'(flags[FAILSAFE_BIT]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_ticks_reg   <= '0;
            tick_count_reg  <= '0;
            frame_start_reg <= '0;
            pos_reg         <= '0;
            lost_reg        <= '0;
            failsafe_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                gap_ticks_reg <= cfg_wr_data;
            end
            if (tick_acc) begin
                tick_count_reg <= tick_count_reg + TICK_W'(1);
            end
            if (restart) begin
                frame_start_reg <= tick_count_reg;
            end
            pos_reg      <= pos_next;
            lost_reg     <= lost_next;
            failsafe_reg <= failsafe_next;
            if (decode) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; loaded only when a frame completes.
    always_ff @(posedge aclk) begin
        if (decode) begin
            for (int c = 0; c < 7; c++) begin
                chan_reg[c] <= chan_next[c];
            end
            link_up_reg <= !flags[FAILSAFE_BIT];
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_chan_one        = chan_reg[0];
    assign m_chan_two        = chan_reg[1];
    assign m_chan_three      = chan_reg[2];
    assign m_chan_four       = chan_reg[3];
    assign m_chan_five       = chan_reg[4];
    assign m_chan_six        = chan_reg[5];
    assign m_chan_seven      = chan_reg[6];
    assign m_lost_frames     = lost_reg;
    assign m_failsafe_frames = failsafe_reg;
    assign m_link_up         = link_up_reg;

    // The byte position never runs past the decoded marker.
    `SFRD_ASSERT_ALWAYS(a_pos_range, !aresetn || pos_reg <= POS_DONE, "byte position out of range")
    // A completed frame always shows up as a result on the next cycle.
    `SFRD_ASSERT(a_decode_valid, decode |=> m_valid, "decoded frame not presented")
    // Flag counters only move together with a fresh result.
    `SFRD_ASSERT(a_count_moves, $changed({lost_reg, failsafe_reg}) |-> m_valid, "counter moved")
    // A taken result is not presented again unless another frame completed.
    `SFRD_ASSERT(a_no_repeat, m_valid && m_ready && !decode |=> !m_valid, "result repeated")

endmodule

// ----- bench/sbus_frame_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Scoreboard for the serial RC frame decoder bench
// Tracks the decoder state from accepted input transactions, keeps the
// decoded frames that are due on the result channel, and compares them.
// ---------------------------------------------------------------------------
package sbus_frame_scoreboard_pkg;

    import sfrd_pkg::*;

    typedef struct packed {
        logic [6:0][CHAN_W-1:0] chan;
        logic [COUNT_W-1:0]     lost_frames;
        logic [COUNT_W-1:0]     failsafe_frames;
        logic                   link_up;
    } frame_result_t;

    class frame_scoreboard;
        logic [BYTE_W-1:0]  gap_ticks;
        logic [TICK_W-1:0]  ticks;
        logic [TICK_W-1:0]  start_tick;
        logic [4:0]         position;
        logic [BYTE_W-1:0]  store [FRAME_BYTES_DEFAULT];
        logic [COUNT_W-1:0] lost;
        logic [COUNT_W-1:0] failsafe;
        frame_result_t      frames_due [$];
        int unsigned        mismatches;

        function new();
            gap_ticks  = '0;
            ticks      = '0;
            start_tick = '0;
            position   = '0;
            lost       = '0;
            failsafe   = '0;
            mismatches = 0;
            foreach (store[i]) store[i] = '0;
        endfunction

        // Unpacks the seven channels and updates the flag counters.
        function frame_result_t unpack_frame();
            frame_result_t r;
            logic [10*BYTE_W-1:0] stream;
            for (int i = 0; i < 10; i++) stream[BYTE_W*i +: BYTE_W] = store[i+1];
            for (int c = 0; c < 7; c++) begin
                r.chan[c] = {1'b0, stream[RAW_W*c +: RAW_W]} + CHAN_OFFSET;
            end
            if (store[23][LOST_BIT]) lost = lost + 1'b1;
            if (store[23][FAILSAFE_BIT]) failsafe = failsafe + 1'b1;
            r.link_up         = !store[23][FAILSAFE_BIT];
            r.lost_frames     = lost;
            r.failsafe_frames = failsafe;
            return r;
        endfunction

        function void note_input(opcode_t op, logic [BYTE_W-1:0] value);
            logic [TICK_W-1:0] elapsed;
            if (op == OP_TICK) begin
                ticks = ticks + 1'b1;
                return;
            end
            elapsed = ticks - start_tick;
            // The restart test comes first, so a restarting sync lands in slot 0.
            if (elapsed >= gap_ticks && value == SYNC_BYTE) begin
                position   = '0;
                start_tick = ticks;
            end
            if (position < FRAME_BYTES_DEFAULT) begin
                store[position] = value;
                position = position + 1'b1;
            end else if (position == FRAME_BYTES_DEFAULT) begin
                position = 5'(FRAME_BYTES_DEFAULT + 1);
                frames_due.push_back(unpack_frame());
            end
        endfunction

        function void note_mismatch(string what, int unsigned want, int unsigned got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s: expected %0d, got %0d", what, want, got);
            end
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t want;
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result transaction with no frame pending");
                return;
            end
            want = frames_due.pop_front();
            for (int c = 0; c < 7; c++) begin
                if (got.chan[c] !== want.chan[c]) begin
                    note_mismatch($sformatf("channel %0d", c + 1), want.chan[c], got.chan[c]);
                end
            end
            if (got.lost_frames !== want.lost_frames) begin
                note_mismatch("lost_frames", want.lost_frames, got.lost_frames);
            end
            if (got.failsafe_frames !== want.failsafe_frames) begin
                note_mismatch("failsafe_frames", want.failsafe_frames, got.failsafe_frames);
            end
            if (got.link_up !== want.link_up) begin
                note_mismatch("link_up", want.link_up, got.link_up);
            end
        endfunction
    endclass

endpackage

// ----- bench/tb_sbus_frame_receiver_decoder_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the serial RC frame receiver and decoder
// Drives serial bytes and heartbeat ticks under random idling on both
// channels, tracks the decoder state in a scoreboard, and checks every
// decoded frame field by field against the frame that is due.
// ---------------------------------------------------------------------------
module tb_sbus_frame_receiver_decoder_top;

    import sfrd_pkg::*;
    import sbus_frame_scoreboard_pkg::*;

    // About two thousand transactions, each at worst behind a pause and a
    // result stall, stay well inside this limit.
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [BYTE_W-1:0]   cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_opcode = 1'b0;
    logic [BYTE_W-1:0]   s_rx_byte = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CHAN_W-1:0]   m_chan_one;
    logic [CHAN_W-1:0]   m_chan_two;
    logic [CHAN_W-1:0]   m_chan_three;
    logic [CHAN_W-1:0]   m_chan_four;
    logic [CHAN_W-1:0]   m_chan_five;
    logic [CHAN_W-1:0]   m_chan_six;
    logic [CHAN_W-1:0]   m_chan_seven;
    logic [COUNT_W-1:0]  m_lost_frames;
    logic [COUNT_W-1:0]  m_failsafe_frames;
    logic                m_link_up;

    frame_scoreboard sb = new();

    // When set, neither side idles; the last phase of the run uses this.
    bit          quiet_run = 1'b0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    frame_result_t got;

    sbus_frame_receiver_decoder_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_chan_one        (m_chan_one),
        .m_chan_two        (m_chan_two),
        .m_chan_three      (m_chan_three),
        .m_chan_four       (m_chan_four),
        .m_chan_five       (m_chan_five),
        .m_chan_six        (m_chan_six),
        .m_chan_seven      (m_chan_seven),
        .m_lost_frames     (m_lost_frames),
        .m_failsafe_frames (m_failsafe_frames),
        .m_link_up         (m_link_up)
    );

    always #2 aclk = ~aclk;

    // Watchdog. A lost or stuck result ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side. Outputs are sampled right at the edge, so the values seen
    // are the ones that held before it, the same ones the block used to
    // decide the handshake. The ready line then stalls in random bursts,
    // except in the quiet phase at the end.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got.chan[0]         = m_chan_one;
            got.chan[1]         = m_chan_two;
            got.chan[2]         = m_chan_three;
            got.chan[3]         = m_chan_four;
            got.chan[4]         = m_chan_five;
            got.chan[5]         = m_chan_six;
            got.chan[6]         = m_chan_seven;
            got.lost_frames     = m_lost_frames;
            got.failsafe_frames = m_failsafe_frames;
            got.link_up         = m_link_up;
            sb.check_result(got);
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet_run && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offers one input transaction and returns at the edge that accepts it.
    // Valid is only lowered when a pause is taken, so back-to-back items keep
    // it high without a second assignment in the same time step.
    task automatic send_item(input opcode_t op, input logic [BYTE_W-1:0] value);
        int unsigned pause;
        if (!quiet_run && $urandom_range(0, 3) == 0) begin
            pause = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_rx_byte <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(op, value);
        items_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] value);
        send_item(OP_BYTE, value);
    endtask

    // A tick carries a random byte that the block must ignore.
    task automatic send_ticks(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) send_item(OP_TICK, BYTE_W'($urandom));
    endtask

    // Sends a sync byte and 24 more bytes, with ticks scattered in between.
    // Mode 1 fills the frame with zeros and mode 2 with ones; otherwise the
    // content is random, with an occasional sync byte in the middle. That
    // sync either restarts the frame or, when it comes too early, is stored
    // as plain data.
    task automatic send_frame(input int unsigned mode);
        logic [TICK_W-1:0] elapsed;
        int unsigned       need;
        logic [BYTE_W-1:0] value;
        elapsed = sb.ticks - sb.start_tick;
        need = (sb.gap_ticks > elapsed) ? sb.gap_ticks - elapsed : 0;
        // Now and then the leading sync is sent too early on purpose.
        if (need > 0 && $urandom_range(0, 9) == 0) begin
            send_ticks($urandom_range(0, need - 1));
        end else begin
            send_ticks(need + $urandom_range(0, 2));
        end
        send_byte(SYNC_BYTE);
        for (int i = 1; i <= FRAME_BYTES_DEFAULT; i++) begin
            if ($urandom_range(0, 7) == 0) send_ticks($urandom_range(1, 3));
            case (mode)
                1: begin
                    value = 8'h00;
                end
                2: begin
                    value = 8'hFF;
                end
                default: begin
                    value = ($urandom_range(0, 19) == 0) ? SYNC_BYTE : BYTE_W'($urandom);
                end
            endcase
            send_byte(value);
        end
    endtask

    // Noise between frames: stray bytes after a completed frame, truncated
    // frames, and runs of ticks.
    task automatic send_noise();
        int unsigned kind;
        int unsigned count;
        kind = $urandom_range(0, 2);
        case (kind)
            0: begin
                count = $urandom_range(1, 6);
                for (int unsigned i = 0; i < count; i++) begin
                    send_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : BYTE_W'($urandom));
                end
            end
            1: begin
                count = $urandom_range(1, 22);
                send_byte(SYNC_BYTE);
                for (int unsigned i = 0; i < count; i++) send_byte(BYTE_W'($urandom));
            end
            default: begin
                send_ticks($urandom_range(1, 10));
            end
        endcase
    endtask

    // Mostly well-formed frames, the rest noise, until the item budget is spent.
    task automatic run_mix(input int unsigned budget);
        int unsigned target;
        int unsigned pick;
        target = items_sent + budget;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) send_frame(0);
            else if (pick < 66) send_frame(1);
            else if (pick < 72) send_frame(2);
            else send_noise();
        end
    endtask

    // Brings the block to idle: no input offered, every due frame received,
    // and enough spare cycles for any ready stall still running out.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.frames_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_gap(input logic [BYTE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.gap_ticks = value;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, with the gap left at its reset value of zero. One
        // frame of all ones with both flags set gives every channel at its
        // top value and link_up low. A stray byte after completion must
        // change nothing, and a sync byte then restarts the frame.
        send_ticks(1);
        send_byte(SYNC_BYTE);
        for (int i = 1; i < 23; i++) send_byte(8'hFF);
        send_byte(8'h0C);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(SYNC_BYTE);

        // Random traffic with no minimum gap: every sync byte restarts.
        run_mix(500);

        // Widest gap: frames need long runs of ticks between them.
        settle();
        write_gap(8'd255);
        run_mix(260);

        // A few middle gap settings.
        for (int k = 0; k < 3; k++) begin
            settle();
            write_gap(BYTE_W'($urandom_range(1, 40)));
            run_mix(200);
        end

        // Last part: gap back to zero and no idling on either side.
        settle();
        write_gap(8'd0);
        quiet_run = 1'b1;
        run_mix(400);

        settle();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.frames_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
